### rtl/carrier_sense_power_floor_core_macros.svh
// ----------------------------------------------------------------------------
// Carrier sense core assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CARRIER_SENSE_POWER_FLOOR_CORE_MACROS_SVH
`define CARRIER_SENSE_POWER_FLOOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("carrier sense check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("carrier sense check failed");

`endif

### rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// Carrier sense package
// Shared widths, constants, register map and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SQ_W     = 31;  // square of a 16-bit signed value
  localparam int unsigned FLOOR_W  = 56;  // Q40.16 floor
  localparam int unsigned ENERGY_W = 39;
  localparam int unsigned TIME_W   = 32;

  localparam logic [FLOOR_W-1:0]  FLOOR_TOP  = {FLOOR_W{1'b1}};
  localparam logic [ENERGY_W-1:0] ENERGY_TOP = {ENERGY_W{1'b1}};

  // Start-up mean power of the floor
  localparam logic [63:0] INIT_MEAN_POWER = 64'd1000000000;

  localparam logic [7:0]  RATIO_RST  = 8'd144;     // 9.0 in Q4.4
  localparam logic [15:0] FMIN_RST   = 16'd25;
  localparam logic [16:0] RISE_RST   = 17'd65569;  // ~1.0005 in Q16
  localparam logic [31:0] REBASE_RST = 32'd60000;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_POLL   = 1'b1
  } csp_func_e;

  typedef enum logic [1:0] {
    REG_BUSY_RATIO  = 2'd0,
    REG_FLOOR_MIN   = 2'd1,
    REG_FLOOR_RISE  = 2'd2,
    REG_REBASE_TIME = 2'd3
  } csp_reg_e;

  typedef struct packed {
    logic [7:0]        busy_ratio;
    logic [15:0]       floor_min;
    logic [16:0]       floor_rise;
    logic [TIME_W-1:0] rebase_time;
  } csp_cfg_t;

  typedef struct packed {
    logic                valid;
    logic                busy;
    logic [ENERGY_W-1:0] energy;
    logic                rebased;
  } csp_res_t;

endpackage

`default_nettype wire

### rtl/csp_cell.sv
// ----------------------------------------------------------------------------
// Carrier sense window cell
// One sample of the sliding window; shifts towards the tail on each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_cell (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                shift_i,
  input  wire logic signed [csp_pkg::SAMPLE_W-1:0] d_i,
  output logic signed      [csp_pkg::SAMPLE_W-1:0] q_o
);
  import csp_pkg::*;

  logic signed [SAMPLE_W-1:0] smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else if (shift_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;

endmodule

`default_nettype wire

### rtl/csp_floor.sv
// ----------------------------------------------------------------------------
// Carrier sense floor unit
// Per-poll noise floor update, busy decision and long-busy rebase.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_floor #(
  parameter int unsigned WINDOW_LEN = 480
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire csp_pkg::csp_cfg_t                            cfg_i,
  input  wire logic                                         start_i,
  input  wire logic [31+$clog2(WINDOW_LEN)-1:0]             energy_i,
  input  wire logic [csp_pkg::TIME_W-1:0]                   now_i,
  input  wire logic                                         out_free_i,
  output logic                                              busy_o,
  output csp_pkg::csp_res_t                                 res_o
);
  import csp_pkg::*;

  localparam int unsigned ESUM_W = 31 + $clog2(WINDOW_LEN);
  localparam int unsigned PQ_W   = ESUM_W + 16;
  localparam int unsigned XW     = (PQ_W > FLOOR_W) ? PQ_W : FLOOR_W;
  localparam int unsigned LHS_W  = ESUM_W + 20;
  localparam int unsigned CW     = (LHS_W > 64) ? LHS_W : 64;
  localparam int unsigned EXW    = (ESUM_W > ENERGY_W) ? ESUM_W : ENERGY_W;
  localparam int unsigned WL_W   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned HALF   = FLOOR_W / 2;
  localparam int unsigned PP_W   = HALF + 17;
  localparam int unsigned PROD_W = FLOOR_W + 17;

  localparam logic [63:0] INIT_RAW = 64'(WINDOW_LEN) * INIT_MEAN_POWER;
  localparam logic [FLOOR_W-1:0] FLOOR_INIT =
    (INIT_RAW > 64'(FLOOR_TOP >> 16)) ? FLOOR_TOP : FLOOR_W'(INIT_RAW << 16);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_CLAMP  = 5'b00100,
    ST_RATIO  = 5'b01000,
    ST_DECIDE = 5'b10000
  } st_e;

  st_e                 state_q, state_d;
  logic [FLOOR_W-1:0]  floor_q, floor_d;
  logic                timing_q, timing_d;
  logic [TIME_W-1:0]   start_ms_q, start_ms_d;

  logic [ESUM_W-1:0]   e_q;
  logic [TIME_W-1:0]   now_q;
  logic [PP_W-1:0]     pp_hi_q, pp_lo_q;
  logic                lt_q;
  logic [FLOOR_W-1:0]  min_q;
  logic [63:0]         rhs_q;

  logic [XW-1:0]       p_x;
  logic [FLOOR_W-1:0]  p_sat;
  logic [PROD_W-1:0]   prod;
  logic [FLOOR_W:0]    grow;
  logic [FLOOR_W-1:0]  grow_sat, floor1, floor2;
  logic [WL_W+15:0]    min_raw;
  logic [CW-1:0]       lhs_x, rhs_x;
  logic                busy_cmp, late, rebase_hit, fire;
  logic [EXW-1:0]      e_x;
  logic [TIME_W-1:0]   elapsed;

  // Power in floor units and its saturated form
  assign p_x   = XW'({e_q, 16'h0});
  assign p_sat = (p_x > XW'(FLOOR_TOP)) ? FLOOR_TOP : p_x[FLOOR_W-1:0];

  // floor * rise >> 16 from two registered partial products
  assign prod     = {pp_hi_q, {HALF{1'b0}}} + PROD_W'(pp_lo_q);
  assign grow     = prod[PROD_W-1:16];
  assign grow_sat = grow[FLOOR_W] ? FLOOR_TOP : grow[FLOOR_W-1:0];
  assign floor1   = lt_q ? p_sat : grow_sat;
  assign floor2   = (floor1 < min_q) ? min_q : floor1;

  assign min_raw  = cfg_i.floor_min * WL_W'(WINDOW_LEN);

  assign lhs_x      = CW'({e_q, 20'h0});
  assign rhs_x      = CW'(rhs_q);
  assign busy_cmp   = lhs_x > rhs_x;
  assign elapsed    = now_q - start_ms_q;
  assign late       = elapsed > cfg_i.rebase_time;
  assign rebase_hit = busy_cmp && timing_q && late;
  assign fire       = (state_q == ST_DECIDE) && out_free_i;

  always_comb begin
    state_d    = state_q;
    floor_d    = floor_q;
    timing_d   = timing_q;
    start_ms_d = start_ms_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_MUL;
      ST_MUL:    state_d = ST_CLAMP;
      ST_CLAMP: begin
        floor_d = floor2;
        state_d = ST_RATIO;
      end
      ST_RATIO:  state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
          if (!busy_cmp) begin
            timing_d = 1'b0;
          end else if (!timing_q) begin
            timing_d   = 1'b1;
            start_ms_d = now_q;
          end else if (late) begin
            floor_d  = p_sat;
            timing_d = 1'b0;
          end
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      floor_q    <= FLOOR_INIT;
      timing_q   <= 1'b0;
      start_ms_q <= '0;
    end else begin
      state_q    <= state_d;
      floor_q    <= floor_d;
      timing_q   <= timing_d;
      start_ms_q <= start_ms_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      e_q   <= energy_i;
      now_q <= now_i;
    end
    if (state_q == ST_MUL) begin
      pp_hi_q <= floor_q[FLOOR_W-1:HALF] * cfg_i.floor_rise;
      pp_lo_q <= floor_q[HALF-1:0] * cfg_i.floor_rise;
      lt_q    <= p_x < XW'(floor_q);
      min_q   <= FLOOR_W'({min_raw, 16'h0});
    end
    if (state_q == ST_RATIO) begin
      rhs_q <= {56'd0, cfg_i.busy_ratio} * {8'd0, floor_q};
    end
  end

  assign e_x = EXW'(e_q);

  always_comb begin
    res_o.valid   = fire;
    res_o.busy    = busy_cmp && !rebase_hit;
    res_o.energy  = (e_x > EXW'(ENERGY_TOP)) ? ENERGY_TOP : e_x[ENERGY_W-1:0];
    res_o.rebased = rebase_hit;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### rtl/carrier_sense_power_floor_core.sv
// ----------------------------------------------------------------------------
// Carrier sense power floor core
// Energy-detect carrier sense with a tracked noise floor.
// ----------------------------------------------------------------------------
// Sample words (tuser func = sample) shift into a chain of WINDOW_LEN cells and
// keep a running sum of squared samples; they return nothing. Sample words are
// taken one per clock without a break. A poll word (func = poll, carrying the
// time in ms) then passes through the floor unit: capture of the window
// energy and the time in the cycle after it is taken, split floor*rise
// multiply, saturate and clamp, ratio multiply, decide. The decision is
// written to the output register at the end of the decide cycle; the unit
// stays in decide while the output side stalls. Samples keep flowing while
// a poll is being worked on; only a further poll waits (tready low for that
// word) until the floor unit is free. Reset clears the window cells directly,
// so there is no clearing pass. The user must write registers over the APB
// port only while the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module carrier_sense_power_floor_core #(
  parameter int unsigned WINDOW_LEN = 480
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // [15:0] sample, [47:16] now_ms
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] func
  // result words
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [0] busy_res, [39:1] window_energy,
                                             // [40] rebased, [47:41] zero
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import csp_pkg::*;

  `include "carrier_sense_power_floor_core_macros.svh"

  localparam int unsigned ESUM_W = 31 + $clog2(WINDOW_LEN);

  // ---- register block ------------------------------------------------------
  csp_cfg_t cfg_q, cfg_d;
  csp_reg_e reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = csp_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_BUSY_RATIO:  cfg_d.busy_ratio  = pwdata[7:0];
        REG_FLOOR_MIN:   cfg_d.floor_min   = pwdata[15:0];
        REG_FLOOR_RISE:  cfg_d.floor_rise  = pwdata[16:0];
        REG_REBASE_TIME: cfg_d.rebase_time = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BUSY_RATIO:  prdata = 32'(cfg_q.busy_ratio);
      REG_FLOOR_MIN:   prdata = 32'(cfg_q.floor_min);
      REG_FLOOR_RISE:  prdata = 32'(cfg_q.floor_rise);
      REG_REBASE_TIME: prdata = cfg_q.rebase_time;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.busy_ratio  <= RATIO_RST;
      cfg_q.floor_min   <= FMIN_RST;
      cfg_q.floor_rise  <= RISE_RST;
      cfg_q.rebase_time <= REBASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- input side ----------------------------------------------------------
  logic                       in_acc, in_poll, poll_pend, floor_busy;
  logic signed [SAMPLE_W-1:0] in_smp;
  logic [TIME_W-1:0]          in_now;
  logic signed [SAMPLE_W-1:0] tap [WINDOW_LEN];
  logic signed [31:0]         sq_new_full, sq_old_full;

  assign in_smp  = s_axis_tdata_i[15:0];
  assign in_now  = s_axis_tdata_i[47:16];
  assign in_poll = (csp_func_e'(s_axis_tuser_i[0]) == FUNC_POLL);

  // a second poll waits while one is still in flight
  assign s_axis_tready_o = !(in_poll && poll_pend);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // ---- window: chain of cells, head takes the new sample -------------------
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      csp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(in_acc && !in_poll),
        .d_i    (in_smp),
        .q_o    (tap[i])
      );
    end else begin : g_body
      csp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(in_acc && !in_poll),
        .d_i    (tap[i-1]),
        .q_o    (tap[i])
      );
    end
  end

  // squares of the incoming sample and of the one falling off the tail
  assign sq_new_full = in_smp * in_smp;
  assign sq_old_full = tap[WINDOW_LEN-1] * tap[WINDOW_LEN-1];

  // ---- stage A: registered squares / poll time -----------------------------
  logic              a_valid_q, a_poll_q;
  logic [SQ_W-1:0]   a_sq_new_q, a_sq_old_q;
  logic [TIME_W-1:0] a_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_poll_q  <= 1'b0;
    end else begin
      a_valid_q <= in_acc;
      a_poll_q  <= in_poll;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_sq_new_q <= sq_new_full[SQ_W-1:0];
      a_sq_old_q <= sq_old_full[SQ_W-1:0];
      a_now_q    <= in_now;
    end
  end

  // ---- stage B: running energy sum -----------------------------------------
  logic [ESUM_W-1:0] energy_q;
  logic              a_smp, a_pol;

  assign a_smp = a_valid_q && !a_poll_q;
  assign a_pol = a_valid_q && a_poll_q;

  // never goes negative: the leaving square is part of the sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else if (a_smp) begin
      energy_q <= energy_q + ESUM_W'(a_sq_new_q) - ESUM_W'(a_sq_old_q);
    end
  end

  assign poll_pend = a_pol || floor_busy;

  // ---- floor unit ----------------------------------------------------------
  csp_res_t res;
  logic     out_free;

  csp_floor #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_floor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (a_pol),
    .energy_i  (energy_q),
    .now_i     (a_now_q),
    .out_free_i(out_free),
    .busy_o    (floor_busy),
    .res_o     (res)
  );

  // ---- output register -----------------------------------------------------
  logic                m_valid_q;
  logic                m_busy_q, m_rebased_q;
  logic [ENERGY_W-1:0] m_energy_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_busy_q    <= res.busy;
      m_energy_q  <= res.energy;
      m_rebased_q <= res.rebased;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, m_rebased_q, m_energy_q, m_busy_q};

  // ---- checks --------------------------------------------------------------
  // a poll only reaches the floor unit when it is free
  `CSP_ASSERT_IMPL(a_poll_unit_free, clk_i, rst_ni, a_pol, !floor_busy)
  // an accepted poll shows up in stage A next cycle
  `CSP_ASSERT_NEXT(a_poll_staged, clk_i, rst_ni, in_acc && in_poll, a_pol)
  // a rebase always clears busy
  `CSP_ASSERT_IMPL(a_rebase_clears_busy, clk_i, rst_ni, m_valid_q, !(m_busy_q && m_rebased_q))
  // the unit never finishes into a full output register
  `CSP_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, res.valid, out_free)

endmodule

`default_nettype wire
